// ===== rtl/peqc_pkg.sv =====
// shared types and constants for the pointer event queue
package peqc_pkg;

  // default ring depth and register reset value
  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam logic [7:0] MAX_COORD_RST = 8'd239;

  // event phase codes
  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_DOWN = 2'd1,
    PH_MOVE = 2'd2,
    PH_UP   = 2'd3
  } phase_t;

  // one queued pointer event
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        has_pos;
    logic        pressed;
    logic        intr;
    logic [31:0] ms;
  } event_t;

  // load command from the controller into the result stage
  typedef struct packed {
    logic   load;
    logic   from_mem;
    event_t evt;
  } stage_cmd_t;

endpackage

// ===== rtl/peqc_if.sv =====
// request and event channel interfaces with valid/ready handshake
interface peqc_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic               is_pressed;
  logic [31:0]        time_ms;

  modport source (output valid, action, pos_x, pos_y, is_pressed, time_ms, input ready);
  modport sink (input valid, action, pos_x, pos_y, is_pressed, time_ms, output ready);
endinterface

interface peqc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  logic        pos_valid;
  logic        out_pressed;
  logic        interrupted;
  logic [31:0] event_ms;

  modport source (output valid, phase, out_x, out_y, pos_valid, out_pressed, interrupted,
                  event_ms, input ready);
  modport sink (input valid, phase, out_x, out_y, pos_valid, out_pressed, interrupted,
                event_ms, output ready);
endinterface

// ===== rtl/peqc_ring.sv =====
// event ring storage: one write port, one registered read port
module peqc_ring #(
  parameter int unsigned QUEUE_DEPTH = peqc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  peqc_pkg::event_t               wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output peqc_pkg::event_t               rd_data
);
  import peqc_pkg::*;

  event_t mem [QUEUE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/peqc_ctrl.sv =====
// queue control: pointers, fill count, overflow marker, last sample, coalescing
module peqc_ctrl #(
  parameter int unsigned QUEUE_DEPTH = peqc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_wdata,
  peqc_in_if.sink                        req,
  input  logic                           stage_free,
  output logic                           wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  output peqc_pkg::event_t               wr_data,
  output logic                           rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output peqc_pkg::stage_cmd_t           cmd
);
  import peqc_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  logic [7:0]    max_coord;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] mem_count;
  logic          marker_valid;
  logic [31:0]   marker_ms;
  logic          tail_move;
  event_t        last_sample;

  logic          acc;
  logic          is_read;
  logic          out_of_range;
  logic          queue_nz;
  logic          full;
  logic          coalesce;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_inc;
  logic [AW-1:0] tail_dec;
  event_t        nx;
  event_t        marker_evt;
  event_t        idle_evt;

  assign req.ready = stage_free;
  assign acc       = req.valid & req.ready;
  assign is_read   = req.action;

  // ring index wrap
  assign head_inc = (head == LAST_ADDR) ? '0 : AW'(head + 1'b1);
  assign tail_inc = (tail == LAST_ADDR) ? '0 : AW'(tail + 1'b1);
  assign tail_dec = (tail == '0) ? LAST_ADDR : AW'(tail - 1'b1);

  // range check against the coordinate limit
  assign out_of_range = req.pos_x[10] | req.pos_y[10]
                      | (req.pos_x[9:0] > {2'b00, max_coord})
                      | (req.pos_y[9:0] > {2'b00, max_coord});

  // queue occupancy, marker counts as one entry
  assign queue_nz = (mem_count != '0) | marker_valid;
  assign full     = (CW'(mem_count + CW'(marker_valid)) == FULL_COUNT);

  // new event from the sample
  always_comb begin
    nx.x       = req.pos_x[7:0];
    nx.y       = req.pos_y[7:0];
    nx.has_pos = 1'b1;
    nx.pressed = req.is_pressed;
    nx.intr    = 1'b0;
    nx.ms      = req.time_ms;
    if (!req.is_pressed) begin
      nx.phase = PH_UP;
    end else if (last_sample.pressed) begin
      nx.phase = PH_MOVE;
    end else begin
      nx.phase = PH_DOWN;
    end
  end

  assign coalesce = queue_nz & (nx.phase == PH_MOVE) & tail_move;

  // interrupted marker and empty-queue reply
  always_comb begin
    marker_evt       = '0;
    marker_evt.phase = PH_NONE;
    marker_evt.intr  = 1'b1;
    marker_evt.ms    = marker_ms;
    idle_evt         = last_sample;
    idle_evt.phase   = PH_NONE;
    idle_evt.intr    = 1'b0;
  end

  // memory write and read requests
  always_comb begin
    wr_en   = acc & ~is_read & ~out_of_range;
    wr_addr = coalesce ? tail_dec : tail;
    wr_data = nx;
    rd_en   = acc & is_read & ~marker_valid & (mem_count != '0);
    rd_addr = head;
  end

  // result stage load
  always_comb begin
    cmd.load     = acc & is_read;
    cmd.from_mem = ~marker_valid & (mem_count != '0);
    cmd.evt      = marker_valid ? marker_evt : idle_evt;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_coord <= MAX_COORD_RST;
    end else if (cfg_we) begin
      max_coord <= cfg_wdata;
    end
  end

  // queue state update
  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      mem_count    <= '0;
      marker_valid <= 1'b0;
      marker_ms    <= '0;
      tail_move    <= 1'b0;
      last_sample  <= '0;
    end else if (acc) begin
      if (is_read) begin
        if (marker_valid) begin
          marker_valid <= 1'b0;
        end else if (mem_count != '0) begin
          head      <= head_inc;
          mem_count <= CW'(mem_count - 1'b1);
        end
      end else if (out_of_range) begin
        last_sample  <= '0;
        head         <= tail;
        mem_count    <= '0;
        marker_valid <= 1'b1;
        marker_ms    <= req.time_ms;
        tail_move    <= 1'b0;
      end else begin
        last_sample <= nx;
        if (!coalesce) begin
          tail      <= tail_inc;
          tail_move <= (nx.phase == PH_MOVE);
          if (full) begin
            head         <= tail;
            mem_count    <= CW'(1);
            marker_valid <= 1'b1;
            marker_ms    <= req.time_ms;
          end else begin
            mem_count <= CW'(mem_count + 1'b1);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/peqc_out.sv =====
// result stage: read-data stage then output register toward the sink
module peqc_out (
  input  logic                 clk,
  input  logic                 rst,
  input  peqc_pkg::stage_cmd_t cmd,
  input  peqc_pkg::event_t     mem_q,
  output logic                 stage_free,
  peqc_out_if.source           evt
);
  import peqc_pkg::*;

  logic   s1_valid;
  logic   s1_from_mem;
  event_t s1_evt;
  logic   out_valid;
  event_t out_data;
  logic   out_free;

  assign out_free   = ~out_valid | evt.ready;
  assign stage_free = ~s1_valid | out_free;

  // read stage, pairs with the ring's read register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stage_free) begin
      s1_valid <= cmd.load;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_free && cmd.load) begin
      s1_from_mem <= cmd.from_mem;
      s1_evt      <= cmd.evt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data <= s1_from_mem ? mem_q : s1_evt;
    end
  end

  // drive the event channel
  assign evt.valid       = out_valid;
  assign evt.phase       = out_data.phase;
  assign evt.out_x       = out_data.x;
  assign evt.out_y       = out_data.y;
  assign evt.pos_valid   = out_data.has_pos;
  assign evt.out_pressed = out_data.pressed;
  assign evt.interrupted = out_data.intr;
  assign evt.event_ms    = out_data.ms;

endmodule

// ===== rtl/pointer_event_queue_coalescing.sv =====
// Pointer event queue with move coalescing. The block takes one request per clock
// cycle on req: a sample (action 0) or a read (action 1). A sample updates the queue
// and produces no event; a read produces exactly one event on evt, which passes from
// the read stage (paired with the ring's registered read) into the output register
// and on to the sink. Requests are held off only when both the read stage and the
// output register hold events the sink has not yet taken. The queue holds QUEUE_DEPTH
// events, an interrupted marker included; that marker lives in a register in front of
// the ring, so every request is at most a single ring write or a single ring read.
// max_coord is written through cfg_we/cfg_wdata and should change only while idle.
module pointer_event_queue_coalescing #(
  parameter int unsigned QUEUE_DEPTH = peqc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  peqc_in_if.sink    req,
  peqc_out_if.source evt
);
  import peqc_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  event_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  event_t        rd_data;
  stage_cmd_t    cmd;
  logic          stage_free;

  // queue control
  peqc_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .stage_free (stage_free),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .cmd        (cmd)
  );

  // event storage
  peqc_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result stages
  peqc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mem_q      (rd_data),
    .stage_free (stage_free),
    .evt        (evt)
  );

endmodule
